// ===== rtl/lrsc_pkg.sv =====
package lrsc_pkg;

   localparam int DATA_W             = 32;
   localparam int DIFF_W             = DATA_W + 1;
   localparam int FRAC_BITS_DEF      = 16;
   localparam int PARALLEL_LIMIT_DEF = 7;
   localparam int DIV_LAT            = DATA_W + 2;
   localparam int CSR_IDX_W          = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MIN_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MIN_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MAX_X = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MAX_Y = 2'd3;

   localparam logic signed [DATA_W-1:0] T_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] T_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] px;
      logic signed [DATA_W-1:0] py;
      logic signed [DATA_W-1:0] dx;
      logic signed [DATA_W-1:0] dy;
      logic                     par_x;
      logic                     par_y;
      logic                     pok;
   } side_type;

   typedef struct packed {
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] quo;
      logic [DATA_W-1:0] nlo;
      logic [DATA_W-1:0] den;
      logic              neg;
      logic              ovf;
   } div_stage_type;

endpackage

// ===== rtl/lrsc_div.sv =====
module lrsc_div
   import lrsc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [DIFF_W-1:0] in_num,
   input  logic signed [DATA_W-1:0] in_den,
   output logic                     out_valid,
   output logic signed [DATA_W-1:0] out_t
);

   logic [DIFF_W-1:0]    num_neg;
   logic [DATA_W-1:0]    num_abs;
   logic [DATA_W-1:0]    den_abs;
   logic [FRAC_BITS-1:0] num_hi;
   logic [DATA_W-1:0]    num_lo;
   div_stage_type        st0_in;

   div_stage_type        st_ff [0:DATA_W];
   logic [DATA_W:0]      vld_ff;

   logic [DATA_W-1:0]        q;
   logic                     sat_pos;
   logic                     sat_neg;
   logic signed [DATA_W-1:0] t_in;
   logic signed [DATA_W-1:0] t_ff;
   logic                     out_vld_ff;

   // magnitude of (diff << FRAC_BITS), split at the quotient width
   always_comb begin
      num_neg = -in_num;
      num_abs = in_num[DIFF_W-1] ? num_neg[DATA_W-1:0] : in_num[DATA_W-1:0];
      den_abs = in_den[DATA_W-1] ? (~in_den + 1'b1) : in_den;
      num_hi  = num_abs[DATA_W-1 -: FRAC_BITS];
      num_lo  = {num_abs[DATA_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      st0_in.rem = DATA_W'(num_hi);
      st0_in.quo = '0;
      st0_in.nlo = num_lo;
      st0_in.den = den_abs;
      st0_in.neg = in_num[DIFF_W-1] ^ in_den[DATA_W-1];
      st0_in.ovf = DATA_W'(num_hi) >= den_abs;
   end

   always_ff @(posedge clock) begin
      st_ff[0] <= st0_in;
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   // one quotient bit per stage
   for (genvar k = 0; k < DATA_W; k++) begin : g_step
      logic [DATA_W:0]   r2;
      logic [DATA_W:0]   r2_sub;
      logic              ge;
      div_stage_type     st_in;

      always_comb begin
         r2     = {st_ff[k].rem, st_ff[k].nlo[DATA_W-1]};
         r2_sub = r2 - {1'b0, st_ff[k].den};
         ge     = r2 >= {1'b0, st_ff[k].den};
         st_in      = st_ff[k];
         st_in.rem  = ge ? r2_sub[DATA_W-1:0] : r2[DATA_W-1:0];
         st_in.quo  = {st_ff[k].quo[DATA_W-2:0], ge};
         st_in.nlo  = {st_ff[k].nlo[DATA_W-2:0], 1'b0};
      end

      always_ff @(posedge clock) begin
         st_ff[k+1] <= st_in;
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
   end

   // sign and saturation
   always_comb begin
      q       = st_ff[DATA_W].quo;
      sat_pos = st_ff[DATA_W].ovf || q[DATA_W-1];
      sat_neg = st_ff[DATA_W].ovf || (q[DATA_W-1] && (|q[DATA_W-2:0]));
      if (st_ff[DATA_W].neg) begin
         t_in = sat_neg ? T_MIN : $signed(-q);
      end else begin
         t_in = sat_pos ? T_MAX : $signed(q);
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[DATA_W];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_t     = t_ff;

endmodule

// ===== rtl/line_rect_slab_clip_unit.sv =====
// channel   direction  handshake              word
// req_      in         start high, busy low   point_x, point_y, dir_x, dir_y
// rsp_      out        rsp_valid strobe       hit, near_x, near_y, far_x, far_y
// csr_      in         csr_we                 csr_index, csr_wdata
//
// one word enters per cycle; busy stays low
// a result passes the input register, the four pipelined dividers and the
// slab, fold, product and output registers; one quotient bit a divider stage
// reset is synchronous and clears the window registers and all valid bits
// the receiver cannot stall, so nothing in the pipeline ever holds
module line_rect_slab_clip_unit
   import lrsc_pkg::*;
#(
   parameter int FRAC_BITS      = FRAC_BITS_DEF,
   parameter int PARALLEL_LIMIT = PARALLEL_LIMIT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [DATA_W-1:0]    req_point_x,
   input  logic signed [DATA_W-1:0]    req_point_y,
   input  logic signed [DATA_W-1:0]    req_dir_x,
   input  logic signed [DATA_W-1:0]    req_dir_y,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic signed [DATA_W-1:0]    rsp_near_x,
   output logic signed [DATA_W-1:0]    rsp_near_y,
   output logic signed [DATA_W-1:0]    rsp_far_x,
   output logic signed [DATA_W-1:0]    rsp_far_y,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DATA_W-1:0]           csr_wdata
);

   localparam logic [DATA_W-1:0] PLIM = DATA_W'(PARALLEL_LIMIT);

   function automatic logic signed [DATA_W-1:0] sat_point(
      input logic signed [2*DATA_W:0] v
   );
      logic fits;
      fits = (&v[2*DATA_W:DATA_W-1]) || !(|v[2*DATA_W:DATA_W-1]);
      if (fits) begin
         return v[DATA_W-1:0];
      end
      return v[2*DATA_W] ? T_MIN : T_MAX;
   endfunction

   logic signed [DATA_W-1:0] clip_min_x_ff, clip_min_y_ff, clip_max_x_ff, clip_max_y_ff;

   logic                     req_fire;
   logic [DATA_W-1:0]        dx_abs, dy_abs;
   logic                     par_x_in, par_y_in, in_x_in, in_y_in;
   logic signed [DIFF_W-1:0] diff_in [0:3];
   side_type                 side_in;

   logic                     a_vld_ff;
   logic signed [DIFF_W-1:0] diff_ff [0:3];
   side_type                 a_side_ff;

   logic [3:0]               dv;
   logic signed [DATA_W-1:0] dt [0:3];
   side_type                 sd_ff [0:DIV_LAT-1];
   logic [DIV_LAT-1:0]       sv_ff;

   logic signed [DATA_W-1:0] x_lo_in, x_hi_in, y_lo_in, y_hi_in;
   logic                     b_vld_ff;
   logic signed [DATA_W-1:0] x_lo_ff, x_hi_ff, y_lo_ff, y_hi_ff;
   side_type                 b_side_ff;

   logic signed [DATA_W-1:0] tmin_in, tmax_in;
   logic                     c_vld_ff, c_ok_ff;
   logic signed [DATA_W-1:0] tmin_ff, tmax_ff;
   side_type                 c_side_ff;

   logic                       e_vld_ff, e_ok_ff;
   logic signed [DATA_W-1:0]   e_px_ff, e_py_ff;
   logic signed [2*DATA_W-1:0] pnx_ff, pny_ff, pfx_ff, pfy_ff;

   logic signed [2*DATA_W-1:0] shx_n, shy_n, shx_f, shy_f;
   logic                       rsp_valid_ff, rsp_hit_ff;
   logic signed [DATA_W-1:0]   near_x_ff, near_y_ff, far_x_ff, far_y_ff;

   assign busy     = 1'b0;
   assign req_fire = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_min_x_ff <= '0;
         clip_min_y_ff <= '0;
         clip_max_x_ff <= '0;
         clip_max_y_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLIP_MIN_X: begin
               clip_min_x_ff <= $signed(csr_wdata);
            end
            CSR_CLIP_MIN_Y: begin
               clip_min_y_ff <= $signed(csr_wdata);
            end
            CSR_CLIP_MAX_X: begin
               clip_max_x_ff <= $signed(csr_wdata);
            end
            CSR_CLIP_MAX_Y: begin
               clip_max_y_ff <= $signed(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   // edge offsets, parallel tests
   always_comb begin
      diff_in[0] = {clip_min_x_ff[DATA_W-1], clip_min_x_ff}
                 - {req_point_x[DATA_W-1], req_point_x};
      diff_in[1] = {clip_max_x_ff[DATA_W-1], clip_max_x_ff}
                 - {req_point_x[DATA_W-1], req_point_x};
      diff_in[2] = {clip_min_y_ff[DATA_W-1], clip_min_y_ff}
                 - {req_point_y[DATA_W-1], req_point_y};
      diff_in[3] = {clip_max_y_ff[DATA_W-1], clip_max_y_ff}
                 - {req_point_y[DATA_W-1], req_point_y};
      dx_abs   = req_dir_x[DATA_W-1] ? (~req_dir_x + 1'b1) : req_dir_x;
      dy_abs   = req_dir_y[DATA_W-1] ? (~req_dir_y + 1'b1) : req_dir_y;
      par_x_in = dx_abs < PLIM;
      par_y_in = dy_abs < PLIM;
      in_x_in  = !(req_point_x < clip_min_x_ff || req_point_x > clip_max_x_ff);
      in_y_in  = !(req_point_y < clip_min_y_ff || req_point_y > clip_max_y_ff);
      side_in.px    = req_point_x;
      side_in.py    = req_point_y;
      side_in.dx    = req_dir_x;
      side_in.dy    = req_dir_y;
      side_in.par_x = par_x_in;
      side_in.par_y = par_y_in;
      side_in.pok   = (!par_x_in || in_x_in) && (!par_y_in || in_y_in);
   end

   always_ff @(posedge clock) begin
      diff_ff   <= diff_in;
      a_side_ff <= side_in;
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= req_fire;
      end
   end

   lrsc_div #(.FRAC_BITS(FRAC_BITS)) u_div_x_lo (
      .clock(clock), .reset(reset), .in_valid(a_vld_ff),
      .in_num(diff_ff[0]), .in_den(a_side_ff.dx), .out_valid(dv[0]), .out_t(dt[0])
   );
   lrsc_div #(.FRAC_BITS(FRAC_BITS)) u_div_x_hi (
      .clock(clock), .reset(reset), .in_valid(a_vld_ff),
      .in_num(diff_ff[1]), .in_den(a_side_ff.dx), .out_valid(dv[1]), .out_t(dt[1])
   );
   lrsc_div #(.FRAC_BITS(FRAC_BITS)) u_div_y_lo (
      .clock(clock), .reset(reset), .in_valid(a_vld_ff),
      .in_num(diff_ff[2]), .in_den(a_side_ff.dy), .out_valid(dv[2]), .out_t(dt[2])
   );
   lrsc_div #(.FRAC_BITS(FRAC_BITS)) u_div_y_hi (
      .clock(clock), .reset(reset), .in_valid(a_vld_ff),
      .in_num(diff_ff[3]), .in_den(a_side_ff.dy), .out_valid(dv[3]), .out_t(dt[3])
   );

   // word context rides beside the dividers
   always_ff @(posedge clock) begin
      sd_ff[0] <= a_side_ff;
      for (int k = 1; k < DIV_LAT; k++) begin
         sd_ff[k] <= sd_ff[k-1];
      end
      if (reset) begin
         sv_ff <= '0;
      end else begin
         sv_ff <= {sv_ff[DIV_LAT-2:0], a_vld_ff};
      end
   end

   // per-axis entry and exit
   always_comb begin
      x_lo_in = (dt[0] < dt[1]) ? dt[0] : dt[1];
      x_hi_in = (dt[0] < dt[1]) ? dt[1] : dt[0];
      y_lo_in = (dt[2] < dt[3]) ? dt[2] : dt[3];
      y_hi_in = (dt[2] < dt[3]) ? dt[3] : dt[2];
      if (sd_ff[DIV_LAT-1].par_x) begin
         x_lo_in = T_MIN;
         x_hi_in = T_MAX;
      end
      if (sd_ff[DIV_LAT-1].par_y) begin
         y_lo_in = T_MIN;
         y_hi_in = T_MAX;
      end
   end

   always_ff @(posedge clock) begin
      x_lo_ff   <= x_lo_in;
      x_hi_ff   <= x_hi_in;
      y_lo_ff   <= y_lo_in;
      y_hi_ff   <= y_hi_in;
      b_side_ff <= sd_ff[DIV_LAT-1];
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= sv_ff[DIV_LAT-1];
      end
   end

   // fold the two slabs
   always_comb begin
      tmin_in = (x_lo_ff > y_lo_ff) ? x_lo_ff : y_lo_ff;
      tmax_in = (x_hi_ff < y_hi_ff) ? x_hi_ff : y_hi_ff;
   end

   always_ff @(posedge clock) begin
      tmin_ff   <= tmin_in;
      tmax_ff   <= tmax_in;
      c_ok_ff   <= b_side_ff.pok && (tmin_in <= tmax_in);
      c_side_ff <= b_side_ff;
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      pnx_ff  <= c_side_ff.dx * tmin_ff;
      pny_ff  <= c_side_ff.dy * tmin_ff;
      pfx_ff  <= c_side_ff.dx * tmax_ff;
      pfy_ff  <= c_side_ff.dy * tmax_ff;
      e_px_ff <= c_side_ff.px;
      e_py_ff <= c_side_ff.py;
      e_ok_ff <= c_ok_ff;
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= c_vld_ff;
      end
   end

   // arithmetic shift is the floor of the scaled product
   always_comb begin
      shx_n = pnx_ff >>> FRAC_BITS;
      shy_n = pny_ff >>> FRAC_BITS;
      shx_f = pfx_ff >>> FRAC_BITS;
      shy_f = pfy_ff >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= e_ok_ff;
      near_x_ff  <= e_ok_ff ? sat_point({{(DATA_W+1){e_px_ff[DATA_W-1]}}, e_px_ff}
                                        + {shx_n[2*DATA_W-1], shx_n}) : '0;
      near_y_ff  <= e_ok_ff ? sat_point({{(DATA_W+1){e_py_ff[DATA_W-1]}}, e_py_ff}
                                        + {shy_n[2*DATA_W-1], shy_n}) : '0;
      far_x_ff   <= e_ok_ff ? sat_point({{(DATA_W+1){e_px_ff[DATA_W-1]}}, e_px_ff}
                                        + {shx_f[2*DATA_W-1], shx_f}) : '0;
      far_y_ff   <= e_ok_ff ? sat_point({{(DATA_W+1){e_py_ff[DATA_W-1]}}, e_py_ff}
                                        + {shy_f[2*DATA_W-1], shy_f}) : '0;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= e_vld_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_near_x = near_x_ff;
   assign rsp_near_y = near_y_ff;
   assign rsp_far_x  = far_x_ff;
   assign rsp_far_y  = far_y_ff;

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (dv == 4'b0000 || dv == 4'b1111) && (dv[0] == sv_ff[DIV_LAT-1]))
      else $error("divider lanes out of step with word context");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_near_x == '0 && rsp_near_y == '0
                                && rsp_far_x == '0 && rsp_far_y == '0)
      else $error("miss word carries nonzero points");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(a_vld_ff, DIV_LAT + 4))
      else $error("result strobe without matching input word");

endmodule
